/* rtl/tfpr_pkg.sv */
// shared types, constants and helpers for the temporal fastest-path relax block
package tfpr_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int ADDR_W       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int VID_W        = 10;
	localparam int TIME_W       = 32;
	localparam int CFG_IDX_W    = 2;

	localparam logic signed [TIME_W-1:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [TIME_W-1:0] INT_MIN = 32'sh8000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QSTART = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QEND   = 2'd2;

	typedef enum logic [1:0] {
		MODE_RELAX   = 2'd0,
		MODE_ROUND   = 2'd1,
		MODE_READ    = 2'd2,
		MODE_RESTART = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ASEL_SRC,
		ASEL_DST,
		ASEL_SWEEP
	} asel_t;

	typedef struct packed {
		logic  capture;
		asel_t asel;
		logic  eval_src;
		logic  update;
		logic  read_res;
		logic  sweep;
		logic  clr_reached;
		logic  set_source;
		logic  restart_res;
		logic  round_res;
	} cmd_t;

	function automatic logic in_range(logic [VID_W-1:0] v);
		return {{(32-VID_W){1'b0}}, v} < 32'(VERTEX_COUNT);
	endfunction

endpackage

/* rtl/tfpr_ctrl.sv */
// controller state machine: sequences relax, read, sweep and clearing passes
module tfpr_ctrl import tfpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  logic             sweep_last,
	output logic             busy,
	output cmd_t             cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RLX_SRC,
		ST_RLX_DST,
		ST_RLX_UPD,
		ST_RD_ISSUE,
		ST_RD_OUT,
		ST_ROUND_SWEEP,
		ST_RST_SWEEP
	} state_t;

	state_t state_q;

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						case (mode_t'(mode))
							MODE_RELAX:   state_q <= ST_RLX_SRC;
							MODE_ROUND:   state_q <= ST_ROUND_SWEEP;
							MODE_READ:    state_q <= ST_RD_ISSUE;
							MODE_RESTART: state_q <= ST_RST_SWEEP;
							default:      state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RLX_SRC:  state_q <= ST_RLX_DST;
				ST_RLX_DST:  state_q <= ST_RLX_UPD;
				ST_RLX_UPD:  state_q <= ST_IDLE;
				ST_RD_ISSUE: state_q <= ST_RD_OUT;
				ST_RD_OUT:   state_q <= ST_IDLE;
				ST_ROUND_SWEEP, ST_RST_SWEEP: begin
					if (sweep_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.asel = ASEL_SRC;
		case (state_q)
			ST_CLEAR: begin
				cmd.asel        = ASEL_SWEEP;
				cmd.sweep       = 1'b1;
				cmd.clr_reached = 1'b1;
			end
			ST_IDLE: begin
				cmd.capture = start;
			end
			ST_RLX_SRC: begin
				cmd.asel = ASEL_SRC;
			end
			ST_RLX_DST: begin
				cmd.asel     = ASEL_DST;
				cmd.eval_src = 1'b1;
			end
			ST_RLX_UPD: begin
				cmd.asel   = ASEL_DST;
				cmd.update = 1'b1;
			end
			ST_RD_ISSUE: begin
				cmd.asel = ASEL_SRC;
			end
			ST_RD_OUT: begin
				cmd.read_res = 1'b1;
			end
			ST_ROUND_SWEEP: begin
				cmd.asel      = ASEL_SWEEP;
				cmd.sweep     = 1'b1;
				cmd.round_res = sweep_last;
			end
			ST_RST_SWEEP: begin
				cmd.asel        = ASEL_SWEEP;
				cmd.sweep       = 1'b1;
				cmd.clr_reached = 1'b1;
				cmd.set_source  = 1'b1;
				cmd.restart_res = sweep_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/tfpr_dpath.sv */
// datapath: vertex store, config registers, relax arithmetic and result registers
module tfpr_dpath import tfpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output logic                     sweep_last,
	input  logic [VID_W-1:0]         src_vertex,
	input  logic [VID_W-1:0]         dst_vertex,
	input  logic signed [TIME_W-1:0] edge_begin,
	input  logic signed [TIME_W-1:0] edge_finish,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [TIME_W-1:0]        cfg_wdata,
	output logic                     done,
	output logic                     joined_frontier,
	output logic [VID_W-1:0]         vertex_id,
	output logic signed [TIME_W-1:0] arrival_time,
	output logic signed [TIME_W-1:0] path_duration
);

	// config registers
	logic [VID_W-1:0]         source_q;
	logic signed [TIME_W-1:0] qstart_q;
	logic signed [TIME_W-1:0] qend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
			qstart_q <= '0;
			qend_q   <= INT_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE: source_q <= cfg_wdata[VID_W-1:0];
				CFG_QSTART: qstart_q <= $signed(cfg_wdata);
				CFG_QEND:   qend_q   <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// captured request
	logic [VID_W-1:0]         s_q;
	logic [VID_W-1:0]         d_q;
	logic signed [TIME_W-1:0] tb_q;
	logic signed [TIME_W-1:0] tf_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			s_q  <= src_vertex;
			d_q  <= dst_vertex;
			tb_q <= edge_begin;
			tf_q <= edge_finish;
		end
	end

	// sweep counter
	logic [ADDR_W-1:0] cnt_q;

	assign sweep_last = (cnt_q == ADDR_W'(VERTEX_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep) begin
			cnt_q <= sweep_last ? '0 : cnt_q + 1'b1;
		end
	end

	// shared address for the store
	logic [ADDR_W-1:0] addr;

	always_comb begin
		case (cmd.asel)
			ASEL_SRC:   addr = ADDR_W'(s_q);
			ASEL_DST:   addr = ADDR_W'(d_q);
			ASEL_SWEEP: addr = cnt_q;
			default:    addr = '0;
		endcase
	end

	// vertex store: {arrival, duration}, reached flag, visited flag
	logic [2*TIME_W-1:0] data_mem [VERTEX_COUNT];
	logic                reach_mem [VERTEX_COUNT];
	logic                vis_mem [VERTEX_COUNT];

	logic [2*TIME_W-1:0] rd_data_q;
	logic                rd_reach_q;
	logic                rd_vis_q;

	logic                data_we;
	logic [2*TIME_W-1:0] data_wd;
	logic                reach_we;
	logic                reach_wd;
	logic                vis_we;
	logic                vis_wd;

	always_ff @(posedge clk) begin
		rd_data_q  <= data_mem[addr];
		rd_reach_q <= reach_mem[addr];
		rd_vis_q   <= vis_mem[addr];
		if (data_we)  data_mem[addr]  <= data_wd;
		if (reach_we) reach_mem[addr] <= reach_wd;
		if (vis_we)   vis_mem[addr]   <= vis_wd;
	end

	// vertex value as seen by the algorithm
	logic signed [TIME_W-1:0] rd_arr;
	logic signed [TIME_W-1:0] rd_dur;
	logic                     s_ok;
	logic                     d_ok;
	logic signed [TIME_W-1:0] arr_s;
	logic signed [TIME_W-1:0] dur_s;
	logic signed [TIME_W-1:0] arr_d;
	logic signed [TIME_W-1:0] dur_d;

	assign rd_arr = $signed(rd_data_q[2*TIME_W-1:TIME_W]);
	assign rd_dur = $signed(rd_data_q[TIME_W-1:0]);
	assign s_ok   = in_range(s_q);
	assign d_ok   = in_range(d_q);
	assign arr_s  = (s_ok && rd_reach_q) ? rd_arr : INT_MAX;
	assign dur_s  = (s_ok && rd_reach_q) ? rd_dur : INT_MAX;
	assign arr_d  = (d_ok && rd_reach_q) ? rd_arr : INT_MAX;
	assign dur_d  = (d_ok && rd_reach_q) ? rd_dur : INT_MAX;

	// tail evaluation: window check and saturated duration
	logic                     elig;
	logic signed [TIME_W+1:0] dsum;
	logic signed [TIME_W-1:0] nd;
	logic                     elig_q;
	logic signed [TIME_W-1:0] nd_q;

	assign elig = (tb_q < qend_q) && (tf_q > qstart_q) && (tf_q <= qend_q) && (tb_q >= arr_s);
	assign dsum = (TIME_W+2)'(dur_s) + (TIME_W+2)'(tf_q) - (TIME_W+2)'(tb_q);

	always_comb begin
		if (dsum[TIME_W+1:TIME_W-1] == 3'b000 || dsum[TIME_W+1:TIME_W-1] == 3'b111) begin
			nd = dsum[TIME_W-1:0];
		end else if (dsum[TIME_W+1]) begin
			nd = INT_MIN;
		end else begin
			nd = INT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_src) begin
			elig_q <= elig;
			nd_q   <= nd;
		end
	end

	// head update
	logic upd;
	logic src_hit;

	assign upd     = cmd.update && elig_q && d_ok && (tf_q < arr_d) && (dur_d > nd_q);
	assign src_hit = in_range(source_q) && (cnt_q == ADDR_W'(source_q));

	assign data_we  = upd || (cmd.sweep && cmd.set_source && src_hit);
	assign data_wd  = upd ? {tf_q, nd_q} : {qstart_q, {TIME_W{1'b0}}};
	assign reach_we = upd || (cmd.sweep && cmd.clr_reached);
	assign reach_wd = upd || (cmd.set_source && src_hit);
	assign vis_we   = upd || cmd.sweep;
	assign vis_wd   = upd;

	// result registers
	logic                     done_q;
	logic                     res_join_q;
	logic [VID_W-1:0]         res_vid_q;
	logic signed [TIME_W-1:0] res_arr_q;
	logic signed [TIME_W-1:0] res_dur_q;
	logic                     src_cfg_ok;

	assign src_cfg_ok = in_range(source_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update || cmd.read_res || cmd.restart_res || cmd.round_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_join_q <= upd && !rd_vis_q;
			res_vid_q  <= d_q;
			res_arr_q  <= upd ? tf_q : arr_d;
			res_dur_q  <= upd ? nd_q : dur_d;
		end else if (cmd.read_res) begin
			res_join_q <= 1'b0;
			res_vid_q  <= s_q;
			res_arr_q  <= arr_s;
			res_dur_q  <= dur_s;
		end else if (cmd.restart_res) begin
			res_join_q <= 1'b0;
			res_vid_q  <= source_q;
			res_arr_q  <= src_cfg_ok ? qstart_q : INT_MAX;
			res_dur_q  <= src_cfg_ok ? '0 : INT_MAX;
		end else if (cmd.round_res) begin
			res_join_q <= 1'b0;
			res_vid_q  <= '0;
			res_arr_q  <= '0;
			res_dur_q  <= '0;
		end
	end

	assign done            = done_q;
	assign joined_frontier = res_join_q;
	assign vertex_id       = res_vid_q;
	assign arrival_time    = res_arr_q;
	assign path_duration   = res_dur_q;

endmodule

/* rtl/temporal_fastest_path_relax.sv */
// top level of the temporal fastest-path edge relaxation block
// relax: tail read, head read and head write of the store, then done from a register;
// read: one store read; end round and restart: a full sweep, one store entry per cycle
// one request at a time, the next taken in the cycle done shows
// reset: config to defaults, then a clearing pass over the reached and visited
// flags with busy high; the receiver cannot stall results
module temporal_fastest_path_relax import tfpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               mode,
	input  logic [VID_W-1:0]         src_vertex,
	input  logic [VID_W-1:0]         dst_vertex,
	input  logic signed [TIME_W-1:0] edge_begin,
	input  logic signed [TIME_W-1:0] edge_finish,
	// config write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [TIME_W-1:0]        cfg_wdata,
	// result channel, one-cycle strobe
	output logic                     done,
	output logic                     joined_frontier,
	output logic [VID_W-1:0]         vertex_id,
	output logic signed [TIME_W-1:0] arrival_time,
	output logic signed [TIME_W-1:0] path_duration
);

	// commands from the controller, sweep status back from the datapath
	cmd_t cmd;
	logic sweep_last;

	// controller: walks each relax request through its store accesses
	// (tail read, head read, head write), a read through a single read, else a full sweep
	tfpr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.sweep_last (sweep_last),
		.busy       (busy),
		.cmd        (cmd)
	);

	// datapath: single-port vertex store with registered read,
	// window check and saturated duration on the tail, compare and
	// write-back on the head, result registers driving the outputs
	tfpr_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sweep_last      (sweep_last),
		.src_vertex      (src_vertex),
		.dst_vertex      (dst_vertex),
		.edge_begin      (edge_begin),
		.edge_finish     (edge_finish),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.joined_frontier (joined_frontier),
		.vertex_id       (vertex_id),
		.arrival_time    (arrival_time),
		.path_duration   (path_duration)
	);

endmodule

/* rtl/tfpr_checker.sv */
// port-level checks for the temporal fastest-path relax block, bound to the top
module tfpr_checker import tfpr_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic                     joined_frontier,
	input logic signed [TIME_W-1:0] arrival_time
);

	// a result only appears once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// a result strobe is never followed directly by another
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a vertex joining the frontier has been reached
	a_join_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(done && joined_frontier) |-> (arrival_time != INT_MAX))
		else $error("frontier join with unreached arrival");

endmodule

bind temporal_fastest_path_relax tfpr_checker u_tfpr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.joined_frontier (joined_frontier),
	.arrival_time    (arrival_time)
);
